[rtl/sfr16_pkg.sv]
// Shared types, codes and helpers for the sync frame receiver (sum16).
// No dependencies; imported by all modules.
package sfr16_pkg;

	// Parser phase, one per header position, then body
	typedef enum logic [2:0] {
		PH_SYNC1 = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_LEN   = 3'd2,
		PH_SEQ   = 3'd3,
		PH_SYS   = 3'd4,
		PH_MOD   = 3'd5,
		PH_KIND  = 3'd6,
		PH_BODY  = 3'd7
	} phase_t;

	// End item status codes
	localparam logic [1:0] ST_GOOD    = 2'd0;
	localparam logic [1:0] ST_BAD_SUM = 2'd1;
	localparam logic [1:0] ST_SHORT   = 2'd2;

	// Reset sync bytes
	localparam logic [7:0] SYNC_FIRST_RST  = 8'hFE;
	localparam logic [7:0] SYNC_SECOND_RST = 8'hEF;

	// Shortest legal frame: sync x2, len, seq, sys, mod, kind, checksum x2
	localparam logic [7:0] MIN_FRAME_LEN = 8'd9;
	// Frame position of the first payload byte
	localparam logic [7:0] PAYLOAD_START = 8'd7;

	// Register indexes
	localparam logic REG_SYNC_FIRST  = 1'b0;
	localparam logic REG_SYNC_SECOND = 1'b1;

	// Known message kinds
	localparam logic [7:0] KIND_A = 8'h01;
	localparam logic [7:0] KIND_B = 8'h02;
	localparam logic [7:0] KIND_C = 8'h04;
	localparam logic [7:0] KIND_D = 8'h06;
	localparam logic [7:0] KIND_E = 8'h23;

	// Sync configuration handed from the register block to the parser
	typedef struct packed {
		logic [7:0] sync_first;
		logic [7:0] sync_second;
	} sync_cfg_t;

	// One result item
	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] msg_kind;
		logic [7:0] frame_seq;
		logic [7:0] source_system;
		logic [7:0] source_module;
		logic [7:0] byte_offset;
		logic       is_end;
		logic [1:0] status;
		logic       kind_known;
	} item_t;

	function automatic logic known_kind(input logic [7:0] k);
		return (k == KIND_A) || (k == KIND_B) || (k == KIND_C) ||
			(k == KIND_D) || (k == KIND_E);
	endfunction

endpackage

[rtl/sfr16_if.sv]
// Valid/ready channel interfaces: received bytes in, result items out.
// Standalone; no package needed.
interface sfr16_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr16_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [7:0] msg_kind;
	logic [7:0] frame_seq;
	logic [7:0] source_system;
	logic [7:0] source_module;
	logic [7:0] byte_offset;
	logic       is_end;
	logic [1:0] status;
	logic       kind_known;

	modport source (
		output valid, output data_byte, output msg_kind, output frame_seq,
		output source_system, output source_module, output byte_offset,
		output is_end, output status, output kind_known, input ready
	);
	modport sink (
		input valid, input data_byte, input msg_kind, input frame_seq,
		input source_system, input source_module, input byte_offset,
		input is_end, input status, input kind_known, output ready
	);
endinterface

[rtl/sfr16_cfg_regs.sv]
// APB-style register block holding the two sync bytes.
// Depends on sfr16_pkg.
module sfr16_cfg_regs
	import sfr16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output sync_cfg_t   cfg
);

	logic [7:0] sync_first_q;
	logic [7:0] sync_second_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Register writes, one per access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_SYNC_FIRST:  sync_first_q  <= pwdata[7:0];
				REG_SYNC_SECOND: sync_second_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_SYNC_FIRST:  prdata = {24'd0, sync_first_q};
			REG_SYNC_SECOND: prdata = {24'd0, sync_second_q};
			default:         prdata = '0;
		endcase
	end

	assign cfg.sync_first  = sync_first_q;
	assign cfg.sync_second = sync_second_q;

endmodule

[rtl/sfr16_parser.sv]
// Frame parser: input byte register, per-byte phase logic, result register.
// Depends on sfr16_pkg and the channel interfaces in sfr16_if.sv.
module sfr16_parser
	import sfr16_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  sync_cfg_t           cfg,
	sfr16_rx_if.sink            rx,
	sfr16_item_if.source        item
);

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	// Result register
	logic       out_valid_q;
	item_t      out_q;
	// Frame state
	phase_t     phase_q, phase_d;
	logic [7:0] len_q, len_d;
	logic [7:0] cnt_q, cnt_d;
	logic [15:0] sum_q, sum_d;
	logic [7:0] sum_lo_q, sum_lo_d;
	logic [7:0] kind_q, kind_d;
	logic [7:0] seq_q, seq_d;
	logic [7:0] sys_q, sys_d;
	logic [7:0] mod_q, mod_d;

	logic       adv;
	logic       proceed;
	logic       res_valid;
	item_t      res;
	logic [8:0] pos_plus2;
	logic [15:0] sum_add;

	// Result slot frees when empty or being taken
	assign adv      = !out_valid_q || item.ready;
	assign proceed  = valid_s1 && adv;
	assign rx.ready = !valid_s1 || adv;

	assign pos_plus2 = {1'b0, cnt_q} + 9'd2;
	assign sum_add   = sum_q + {8'd0, byte_s1};

	// Input byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// Next-state and result logic for the byte in the input stage
	always_comb begin
		phase_d   = phase_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		sum_d     = sum_q;
		sum_lo_d  = sum_lo_q;
		kind_d    = kind_q;
		seq_d     = seq_q;
		sys_d     = sys_q;
		mod_d     = mod_q;
		res_valid = 1'b0;
		res       = '0;
		res.msg_kind      = kind_q;
		res.frame_seq     = seq_q;
		res.source_system = sys_q;
		res.source_module = mod_q;
		res.kind_known    = known_kind(kind_q);

		unique case (phase_q)
			PH_SYNC1: begin
				if (byte_s1 == cfg.sync_first) phase_d = PH_SYNC2;
			end
			PH_SYNC2: begin
				if (byte_s1 == cfg.sync_second) begin
					sum_d   = {8'd0, cfg.sync_first} + {8'd0, cfg.sync_second};
					cnt_d   = 8'd2;
					phase_d = PH_LEN;
				end else if (byte_s1 != cfg.sync_first) begin
					phase_d = PH_SYNC1;
				end
			end
			PH_LEN: begin
				len_d = byte_s1;
				sum_d = sum_add;
				cnt_d = 8'd3;
				if (byte_s1 < MIN_FRAME_LEN) begin
					// short length: reject with an all-zero header
					phase_d    = PH_SYNC1;
					res_valid  = 1'b1;
					res        = '0;
					res.is_end = 1'b1;
					res.status = ST_SHORT;
				end else begin
					phase_d = PH_SEQ;
				end
			end
			PH_SEQ: begin
				seq_d   = byte_s1;
				sum_d   = sum_add;
				cnt_d   = 8'd4;
				phase_d = PH_SYS;
			end
			PH_SYS: begin
				sys_d   = byte_s1;
				sum_d   = sum_add;
				cnt_d   = 8'd5;
				phase_d = PH_MOD;
			end
			PH_MOD: begin
				mod_d   = byte_s1;
				sum_d   = sum_add;
				cnt_d   = 8'd6;
				phase_d = PH_KIND;
			end
			PH_KIND: begin
				kind_d  = byte_s1;
				sum_d   = sum_add;
				cnt_d   = 8'd7;
				phase_d = PH_BODY;
			end
			PH_BODY: begin
				if (pos_plus2 < {1'b0, len_q}) begin
					// payload byte
					sum_d           = sum_add;
					cnt_d           = cnt_q + 8'd1;
					res_valid       = 1'b1;
					res.data_byte   = byte_s1;
					res.byte_offset = cnt_q - PAYLOAD_START;
				end else if (pos_plus2 == {1'b0, len_q}) begin
					// checksum low byte
					sum_lo_d = byte_s1;
					cnt_d    = cnt_q + 8'd1;
				end else begin
					// checksum high byte closes the frame
					phase_d    = PH_SYNC1;
					cnt_d      = 8'd0;
					res_valid  = 1'b1;
					res.is_end = 1'b1;
					res.status = ((sum_lo_q == sum_q[7:0]) && (byte_s1 == sum_q[15:8]))
						? ST_GOOD : ST_BAD_SUM;
				end
			end
			default: phase_d = PH_SYNC1;
		endcase
	end

	// Frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC1;
			len_q    <= '0;
			cnt_q    <= '0;
			sum_q    <= '0;
			sum_lo_q <= '0;
			kind_q   <= '0;
			seq_q    <= '0;
			sys_q    <= '0;
			mod_q    <= '0;
		end else if (proceed) begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			cnt_q    <= cnt_d;
			sum_q    <= sum_d;
			sum_lo_q <= sum_lo_d;
			kind_q   <= kind_d;
			seq_q    <= seq_d;
			sys_q    <= sys_d;
			mod_q    <= mod_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= proceed && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && res_valid) begin
			out_q <= res;
		end
	end

	assign item.valid         = out_valid_q;
	assign item.data_byte     = out_q.data_byte;
	assign item.msg_kind      = out_q.msg_kind;
	assign item.frame_seq     = out_q.frame_seq;
	assign item.source_system = out_q.source_system;
	assign item.source_module = out_q.source_module;
	assign item.byte_offset   = out_q.byte_offset;
	assign item.is_end        = out_q.is_end;
	assign item.status        = out_q.status;
	assign item.kind_known    = out_q.kind_known;

endmodule

[rtl/sync_frame_receiver_sum16_core.sv]
// Top level of the sync frame receiver with 16-bit additive checksum.
// Depends on sfr16_pkg, sfr16_if.sv, sfr16_cfg_regs and sfr16_parser.
//
// Usage:
//   rx   - valid/ready channel of received bytes, one byte per transaction.
//   item - valid/ready channel of result items: one per payload byte, tagged
//          with kind, sequence, system, module and payload offset, and one
//          end item per frame with status good, checksum mismatch or short
//          length. Header and sync bytes produce no item, except a short length byte.
//   APB  - sync_first at 0x0, sync_second at 0x4; write only while idle.
// Throughput: one byte per cycle, sustained while item.ready stays high; the phase
//   update sits between the input byte register and the result register.
// Path: an accepted byte is held in the input byte register, then parsed into the
//   result register, from which its item is offered on the item channel.
// Stall: the result register holds while item.ready is low; one more byte
//   waits in the input register, then rx.ready drops until the item is taken.
// Reset: arst_n clears the hunt back to the first sync byte, empties both
//   stages and restores the sync bytes to 0xFE and 0xEF.
module sync_frame_receiver_sum16_core
	import sfr16_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	sfr16_rx_if.sink      rx,
	sfr16_item_if.source  item
);

	sync_cfg_t cfg;

	sfr16_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sfr16_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.rx     (rx),
		.item   (item)
	);

endmodule

[tb/tb_sync_frame_receiver_sum16_core.sv]
// Self-checking testbench for sync_frame_receiver_sum16_core: byte streams with random
// gaps and stalls, every result item checked against a frame predictor in a scoreboard.
// Depends on sfr16_pkg, the channel interfaces in sfr16_if.sv and the core RTL.
module tb_sync_frame_receiver_sum16_core;
	timeunit 1ns;
	timeprecision 1ps;

	import sfr16_pkg::*;

	localparam int unsigned IDLE_PCT       = 35;
	localparam int unsigned RX_HOLD_CYCLES = 60;
	localparam int unsigned QUIET_LIMIT    = 1000;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned MAX_REPORTS    = 30;

	// Frame parser predictor plus the queue of result items it expects
	class frame_scoreboard;
		phase_t      ph;
		logic [7:0]  sync_a;
		logic [7:0]  sync_b;
		logic [7:0]  flen;
		logic [7:0]  pos;
		logic [7:0]  sum_lo;
		logic [7:0]  kind;
		logic [7:0]  seq;
		logic [7:0]  sys;
		logic [7:0]  src_mod;
		logic [15:0] sum;
		item_t       expected_q[$];
		int unsigned mismatches;
		int unsigned payload_seen;
		int unsigned good_seen;
		int unsigned bad_seen;
		int unsigned short_seen;

		function new();
			ph = PH_SYNC1;
			sync_a = SYNC_FIRST_RST;
			sync_b = SYNC_SECOND_RST;
			flen = '0;
			pos = '0;
			sum_lo = '0;
			kind = '0;
			seq = '0;
			sys = '0;
			src_mod = '0;
			sum = '0;
			mismatches = 0;
			payload_seen = 0;
			good_seen = 0;
			bad_seen = 0;
			short_seen = 0;
		endfunction

		function void set_sync(logic idx, logic [7:0] value);
			if (idx == REG_SYNC_FIRST) begin
				sync_a = value;
			end else begin
				sync_b = value;
			end
		endfunction

		// Header fields latched for the frame in progress
		function item_t add_header(item_t it);
			it.msg_kind = kind;
			it.frame_seq = seq;
			it.source_system = sys;
			it.source_module = src_mod;
			it.kind_known = (kind == KIND_A) || (kind == KIND_B) || (kind == KIND_C) ||
				(kind == KIND_D) || (kind == KIND_E);
			return it;
		endfunction

		// One accepted byte: advance the parser, queue the item it causes
		function void note_byte(logic [7:0] b);
			item_t it;
			it = '0;
			case (ph)
				PH_SYNC1: begin
					if (b == sync_a)
						ph = PH_SYNC2;
				end
				PH_SYNC2: begin
					// a repeated first sync byte keeps waiting for the second
					if (b == sync_b) begin
						sum = {8'h00, sync_a} + {8'h00, sync_b};
						pos = 8'd2;
						ph = PH_LEN;
					end else if (b != sync_a) begin
						ph = PH_SYNC1;
					end
				end
				PH_LEN: begin
					flen = b;
					sum = sum + {8'h00, b};
					pos = 8'd3;
					if (b < MIN_FRAME_LEN) begin
						// short length: status item only, header fields zero
						it.is_end = 1'b1;
						it.status = ST_SHORT;
						expected_q.push_back(it);
						ph = PH_SYNC1;
					end else begin
						ph = PH_SEQ;
					end
				end
				PH_SEQ: begin
					seq = b;
					sum = sum + {8'h00, b};
					pos = 8'd4;
					ph = PH_SYS;
				end
				PH_SYS: begin
					sys = b;
					sum = sum + {8'h00, b};
					pos = 8'd5;
					ph = PH_MOD;
				end
				PH_MOD: begin
					src_mod = b;
					sum = sum + {8'h00, b};
					pos = 8'd6;
					ph = PH_KIND;
				end
				PH_KIND: begin
					kind = b;
					sum = sum + {8'h00, b};
					pos = 8'd7;
					ph = PH_BODY;
				end
				PH_BODY: begin
					if (int'(pos) + 2 < int'(flen)) begin
						sum = sum + {8'h00, b};
						it.data_byte = b;
						it.byte_offset = pos - PAYLOAD_START;
						expected_q.push_back(add_header(it));
						pos = pos + 8'd1;
					end else if (int'(pos) + 2 == int'(flen)) begin
						sum_lo = b;
						pos = pos + 8'd1;
					end else begin
						// checksum high byte closes the frame
						it.is_end = 1'b1;
						it.status = (sum_lo == sum[7:0] && b == sum[15:8]) ?
							ST_GOOD : ST_BAD_SUM;
						expected_q.push_back(add_header(it));
						pos = 8'd0;
						ph = PH_SYNC1;
					end
				end
			endcase
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("[%0t] MISMATCH %s", $time, what);
		endtask

		// Compare one accepted result with the oldest expected item
		task check_item(item_t got);
			item_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result %h with nothing expected", got));
			end else begin
				want = expected_q.pop_front();
				if (got.data_byte !== want.data_byte)
					report($sformatf("data_byte %h, want %h", got.data_byte, want.data_byte));
				if (got.msg_kind !== want.msg_kind)
					report($sformatf("msg_kind %h, want %h", got.msg_kind, want.msg_kind));
				if (got.frame_seq !== want.frame_seq)
					report($sformatf("frame_seq %h, want %h", got.frame_seq, want.frame_seq));
				if (got.source_system !== want.source_system)
					report($sformatf("source_system %h, want %h",
						got.source_system, want.source_system));
				if (got.source_module !== want.source_module)
					report($sformatf("source_module %h, want %h",
						got.source_module, want.source_module));
				if (got.byte_offset !== want.byte_offset)
					report($sformatf("byte_offset %0d, want %0d",
						got.byte_offset, want.byte_offset));
				if (got.is_end !== want.is_end)
					report($sformatf("is_end %b, want %b", got.is_end, want.is_end));
				if (got.status !== want.status)
					report($sformatf("status %0d, want %0d", got.status, want.status));
				if (got.kind_known !== want.kind_known)
					report($sformatf("kind_known %b, want %b", got.kind_known, want.kind_known));
				if (!want.is_end) begin
					payload_seen++;
				end else if (want.status == ST_GOOD) begin
					good_seen++;
				end else if (want.status == ST_BAD_SUM) begin
					bad_seen++;
				end else begin
					short_seen++;
				end
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bit          tx_steady;
	bit          rx_steady;
	bit          rx_hold_req;
	int unsigned bytes_sent;
	int unsigned settings_run;

	frame_scoreboard sb = new();

	sfr16_rx_if   rx_ch ();
	sfr16_item_if item_ch ();

	sync_frame_receiver_sum16_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rx      (rx_ch),
		.item    (item_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Offer one byte, after a random gap unless tx_steady is set, and wait for the transaction
	task automatic send_byte(input logic [7:0] b);
		while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	// Whole frame with the current sync bytes; hdr packs seq, sys, mod, kind
	task automatic send_frame(input logic [7:0] len, input logic [31:0] hdr,
			input logic [7:0] payload[$], input bit corrupt, input int unsigned extra_sync);
		logic [7:0]  frame_q[$];
		logic [15:0] csum;
		frame_q = {sb.sync_a, sb.sync_b, len, hdr[31:24], hdr[23:16], hdr[15:8], hdr[7:0]};
		frame_q = {frame_q, payload};
		csum = '0;
		foreach (frame_q[i])
			csum = csum + {8'h00, frame_q[i]};
		if (corrupt)
			csum = csum ^ 16'($urandom_range(16'hFFFF, 1));
		frame_q.push_back(csum[7:0]);
		frame_q.push_back(csum[15:8]);
		repeat (extra_sync) send_byte(sb.sync_a);
		foreach (frame_q[i])
			send_byte(frame_q[i]);
	endtask

	// Mostly well-formed frames, some short lengths, broken openings and noise
	task automatic run_random(input int unsigned budget);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned len;
		int unsigned extra;
		logic [31:0] hdr;
		logic [7:0]  payload[$];
		logic [7:0]  known_list[5];
		known_list = '{KIND_A, KIND_B, KIND_C, KIND_D, KIND_E};
		stop_at = bytes_sent + budget;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				pick = $urandom_range(99);
				if (pick < 90) begin
					len = $urandom_range(24, 9);
				end else if (pick < 98) begin
					len = $urandom_range(60, 25);
				end else begin
					len = $urandom_range(255, 200);
				end
				hdr = $urandom;
				if ($urandom_range(1))
					hdr[7:0] = known_list[$urandom_range(4)];
				extra = 0;
				if (sb.sync_a != sb.sync_b && $urandom_range(9) == 0)
					extra = $urandom_range(2, 1);
				payload = {};
				repeat (len - 9) payload.push_back(8'($urandom));
				send_frame(8'(len), hdr, payload, $urandom_range(99) < 15, extra);
			end else if (pick < 75) begin
				send_byte(sb.sync_a);
				send_byte(sb.sync_b);
				send_byte(8'($urandom_range(8)));
			end else if (pick < 88) begin
				// first sync byte followed by an arbitrary second byte
				send_byte(sb.sync_a);
				send_byte(8'($urandom));
			end else begin
				repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
			end
		end
	endtask

	// Stop offering, wait out every expected item and the pipeline
	task automatic quiesce();
		rx_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write, then read back; only the low byte is significant
	task automatic write_sync(input logic idx, input logic [7:0] value);
		logic [2:0] addr;
		addr = {idx, 2'b00};
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {24'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_sync(idx, value);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[7:0] !== value)
			sb.report($sformatf("register %0d reads %h, want %h", idx, prdata[7:0], value));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_sync(input logic [7:0] first, input logic [7:0] second);
		quiesce();
		write_sync(REG_SYNC_FIRST, first);
		write_sync(REG_SYNC_SECOND, second);
		settings_run++;
	endtask

	// Reset, directed frames, then random phases under several sync settings
	initial begin
		logic [7:0] no_payload[$];
		logic [7:0] extreme_q[$];
		logic [7:0] big_q[$];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		rx_hold_req = 1'b0;
		bytes_sent = 0;
		settings_run = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// repeated first sync byte, then the shortest frame with a known kind
		send_frame(MIN_FRAME_LEN, {8'h00, 8'hFF, 8'h80, KIND_A}, no_payload, 1'b0, 1);
		// length one below the minimum
		send_byte(SYNC_FIRST_RST);
		send_byte(SYNC_SECOND_RST);
		send_byte(MIN_FRAME_LEN - 8'd1);
		// extreme payload bytes under a corrupted checksum
		extreme_q = {8'h00, 8'hFF};
		send_frame(8'd11, {8'hFF, 8'h00, 8'h7F, KIND_E}, extreme_q, 1'b1, 0);

		// result side held off while the sender runs flat out
		tx_steady = 1'b1;
		rx_hold_req = 1'b1;
		run_random(100);
		tx_steady = 1'b0;
		run_random(150);

		// stretch with no idling on either side, including a maximum-length frame
		apply_sync(8'h00, 8'hFF);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		repeat (255 - 9) big_q.push_back(8'($urandom));
		send_frame(8'd255, $urandom, big_q, 1'b0, 0);
		run_random(60);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		run_random(40);

		apply_sync(8'hFF, 8'h00);
		run_random(230);

		// both sync bytes equal
		apply_sync(8'h55, 8'h55);
		run_random(230);

		apply_sync(8'($urandom), 8'($urandom));
		run_random(230);

		quiesce();
		$display("Run: %0d bytes sent under %0d sync settings, with a long result stall",
			bytes_sent, settings_run);
		$display("Checked %0d payload items, frame ends: %0d good, %0d bad sum, %0d short",
			sb.payload_seen, sb.good_seen, sb.bad_seen, sb.short_seen);
		if (sb.mismatches == 0) begin
			$display("sync_frame_receiver_sum16_core verification clean");
		end else begin
			$display("sync_frame_receiver_sum16_core verification failed");
		end
		$finish;
	end

	// Result side: random backpressure, one long hold on request
	initial begin
		item_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				item_ch.ready <= 1'b0;
				repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				item_ch.ready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin : result_monitor
		item_t got;
		if (arst_n && item_ch.valid && item_ch.ready) begin
			got = {item_ch.data_byte, item_ch.msg_kind, item_ch.frame_seq,
				item_ch.source_system, item_ch.source_module, item_ch.byte_offset,
				item_ch.is_end, item_ch.status, item_ch.kind_known};
			sb.check_item(got);
		end
	end

	// Watchdog: too many cycles without any transaction ends the run
	initial begin
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((rx_ch.valid && rx_ch.ready) || (item_ch.valid && item_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
		$display("sync_frame_receiver_sum16_core verification failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/sfr16_pkg.sv
rtl/sfr16_if.sv
rtl/sfr16_cfg_regs.sv
rtl/sfr16_parser.sv
rtl/sync_frame_receiver_sum16_core.sv
tb/tb_sync_frame_receiver_sum16_core.sv
